@@ sv/f32_pkg.sv @@
// package for the single-precision arithmetic core
// operation codes, status codes, sequencer state codes and format constants; no dependencies
package f32_pkg;
    localparam int MANT_BITS = 24;
    localparam int EXP_BITS  = 8;
    localparam int BIAS      = 127;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_UNF  = 2'd2,
        ST_DIVZ = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ALIGN = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_NORM  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;
endpackage

@@ sv/float32_add_sub_mul_div_core.sv @@
// single-precision add, subtract, multiply and divide core with truncation
// depends on f32_pkg
//
// usage: present req_type, operand_a and operand_b on s_ with s_valid; the
// word is taken when s_valid and s_ready are both high. s_ready is high only
// while the core is idle: one operation runs at a time on a shared datapath.
// the result word (m_result, m_status) is held on m_ with m_valid until
// m_ready takes it; a stalled receiver simply holds the core in that state.
// the next word can be taken in the cycle after the result word is taken.
// steps from accept to m_valid:
//   add/sub: one alignment shift per exponent bit of difference, the add or
//            subtract, then one step per normalizing shift
//   multiply: one shift-add step per multiplier bit
//   divide: one restoring quotient bit per cycle
// the sequencer in state_reg runs these steps in this order.
// status: 0 ok, 1 exponent overflow, 2 underflow, 3 divide by zero; on any
// error the result is zero. reset (aresetn low, synchronous) returns the core
// to idle with no word pending.
module float32_add_sub_mul_div_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result,
    output logic [1:0]  m_status
);
    f32_pkg::state_t state_reg, state_next;

    logic              sl_reg;        // result sign
    logic signed [10:0] e_reg;        // working exponent
    logic [23:0]       ml_reg;        // larger / multiplicand / divisor
    logic [23:0]       ms_reg;        // smaller / multiplier
    logic [47:0]       acc_reg;       // product / remainder
    logic [24:0]       q_reg;         // quotient / sum
    logic [5:0]        cnt_reg;       // align distance / step counter
    logic              sub_reg;
    logic [1:0]        op_reg;
    logic [31:0]       res_reg;
    logic [1:0]        st_reg;

    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_ge;
    logic [24:0] rem_try;

    assign s_ready  = (state_reg == f32_pkg::S_IDLE);
    assign m_valid  = (state_reg == f32_pkg::S_OUT);
    assign m_result = res_reg;
    assign m_status = st_reg;

    always_comb begin
        sa = s_operand_a[31];
        sb = s_operand_b[31] ^ (s_req_type == f32_pkg::OP_SUB);
        ea = s_operand_a[30:23];
        eb = s_operand_b[30:23];
        ma = (ea != 8'd0) ? {1'b1, s_operand_a[22:0]} : 24'd0;
        mb = (eb != 8'd0) ? {1'b1, s_operand_b[22:0]} : 24'd0;
        a_ge = {ea, ma} >= {eb, mb};
        rem_try = {acc_reg[23:0], 1'b0} - {1'b0, ml_reg};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            f32_pkg::S_IDLE:  if (s_valid) state_next = f32_pkg::S_ALIGN;
            f32_pkg::S_ALIGN: state_next = state_reg;
            f32_pkg::S_MUL:   state_next = state_reg;
            f32_pkg::S_DIV:   state_next = state_reg;
            f32_pkg::S_NORM:  state_next = state_reg;
            f32_pkg::S_OUT:   if (m_ready) state_next = f32_pkg::S_IDLE;
            default:          state_next = f32_pkg::S_IDLE;
        endcase
    end

    // range check and pack
    function automatic logic [33:0] pack(input logic s, input logic signed [10:0] e,
                                         input logic [23:0] m);
        if (e > 11'sd255) return {32'd0, f32_pkg::ST_OVF};
        if (e < 11'sd1) return {32'd0, f32_pkg::ST_UNF};
        return {s, e[7:0], m[22:0], f32_pkg::ST_OK};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= f32_pkg::S_IDLE;
        end else begin
            unique case (state_reg)
                f32_pkg::S_IDLE: begin
                    state_reg <= state_next;
                    if (s_valid) begin
                        op_reg  <= s_req_type;
                        st_reg  <= f32_pkg::ST_OK;
                        res_reg <= 32'd0;
                        acc_reg <= 48'd0;
                        q_reg   <= 25'd0;
                        if (s_req_type[1] == 1'b0) begin
                            sub_reg <= sa ^ sb;
                            if (ea == 8'd0 && eb == 8'd0) begin
                                state_reg <= f32_pkg::S_OUT;
                            end else if (ea == 8'd0) begin
                                res_reg <= {sb, s_operand_b[30:0]};
                                state_reg <= f32_pkg::S_OUT;
                            end else if (eb == 8'd0) begin
                                res_reg <= s_operand_a;
                                state_reg <= f32_pkg::S_OUT;
                            end else begin
                                sl_reg  <= a_ge ? sa : sb;
                                e_reg   <= {3'd0, a_ge ? ea : eb};
                                ml_reg  <= a_ge ? ma : mb;
                                ms_reg  <= a_ge ? mb : ma;
                                cnt_reg <= (a_ge ? (ea - eb) : (eb - ea)) > 8'd23 ? 6'd24
                                         : 6'((a_ge ? (ea - eb) : (eb - ea)));
                                state_reg <= f32_pkg::S_ALIGN;
                            end
                        end else begin
                            sl_reg  <= s_operand_a[31] ^ s_operand_b[31];
                            ml_reg  <= ma;
                            ms_reg  <= mb;
                            cnt_reg <= 6'd0;
                            if (s_req_type == f32_pkg::OP_DIV && eb == 8'd0) begin
                                st_reg <= f32_pkg::ST_DIVZ;
                                state_reg <= f32_pkg::S_OUT;
                            end else if (ea == 8'd0 || eb == 8'd0) begin
                                state_reg <= f32_pkg::S_OUT;
                            end else if (s_req_type == f32_pkg::OP_MUL) begin
                                e_reg <= 11'(ea) + 11'(eb) - 11'(f32_pkg::BIAS);
                                state_reg <= f32_pkg::S_MUL;
                            end else begin
                                e_reg <= 11'(ea) - 11'(eb) + 11'(f32_pkg::BIAS);
                                ml_reg <= mb;
                                acc_reg <= {24'd0, ma};
                                state_reg <= f32_pkg::S_DIV;
                            end
                        end
                    end
                end
                f32_pkg::S_ALIGN: begin
                    if (cnt_reg >= 6'd24 || ms_reg == 24'd0) begin
                        res_reg <= {sl_reg, e_reg[7:0], ml_reg[22:0]};
                        state_reg <= f32_pkg::S_OUT;
                    end else if (cnt_reg != 6'd0) begin
                        ms_reg  <= ms_reg >> 1;
                        cnt_reg <= cnt_reg - 6'd1;
                    end else if (!sub_reg) begin
                        q_reg <= {1'b0, ml_reg} + {1'b0, ms_reg};
                        state_reg <= f32_pkg::S_NORM;
                    end else if (ml_reg == ms_reg) begin
                        state_reg <= f32_pkg::S_OUT;
                    end else begin
                        q_reg <= {1'b0, ml_reg - ms_reg};
                        state_reg <= f32_pkg::S_NORM;
                    end
                end
                f32_pkg::S_MUL: begin
                    // shift-add, multiplier lsb first
                    acc_reg <= {(acc_reg[47:24] + 25'(ms_reg[0] ? ml_reg : 24'd0)),
                                acc_reg[23:1]};
                    ms_reg  <= ms_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd23) begin
                        state_reg <= f32_pkg::S_NORM;
                    end
                end
                f32_pkg::S_DIV: begin
                    // restoring step on the remainder, 25 quotient bits
                    if (cnt_reg == 6'd0) begin
                        q_reg <= {24'd0, acc_reg[23:0] >= ml_reg};
                        if (acc_reg[23:0] >= ml_reg)
                            acc_reg[23:0] <= acc_reg[23:0] - ml_reg;
                    end else begin
                        q_reg <= {q_reg[23:0], ~rem_try[24]};
                        acc_reg[23:0] <= rem_try[24] ? {acc_reg[22:0], 1'b0}
                                                     : rem_try[23:0];
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd24) begin
                        state_reg <= f32_pkg::S_NORM;
                    end
                end
                f32_pkg::S_NORM: begin
                    state_reg <= f32_pkg::S_OUT;
                    if (op_reg == f32_pkg::OP_MUL) begin
                        if (acc_reg[47])
                            {res_reg, st_reg} <= pack(sl_reg, e_reg + 11'sd1, acc_reg[47:24]);
                        else
                            {res_reg, st_reg} <= pack(sl_reg, e_reg, acc_reg[46:23]);
                    end else if (op_reg == f32_pkg::OP_DIV) begin
                        if (q_reg[24])
                            {res_reg, st_reg} <= pack(sl_reg, e_reg, q_reg[24:1]);
                        else
                            {res_reg, st_reg} <= pack(sl_reg, e_reg - 11'sd1, q_reg[23:0]);
                    end else if (q_reg[24]) begin
                        {res_reg, st_reg} <= pack(sl_reg, e_reg + 11'sd1, q_reg[24:1]);
                    end else if (q_reg[23]) begin
                        {res_reg, st_reg} <= pack(sl_reg, e_reg, q_reg[23:0]);
                    end else begin
                        q_reg <= q_reg << 1;
                        e_reg <= e_reg - 11'sd1;
                        state_reg <= f32_pkg::S_NORM;
                    end
                end
                f32_pkg::S_OUT: state_reg <= state_next;
                default: state_reg <= f32_pkg::S_IDLE;
            endcase
        end
    end
endmodule

@@ tb/sv/float32_add_sub_mul_div_core_tb.sv @@
// testbench for the single-precision add, subtract, multiply and divide core
// depends on f32_pkg and float32_add_sub_mul_div_core
`timescale 1ns / 1ps

module float32_add_sub_mul_div_core_tb;
    typedef struct packed {
        logic [31:0]      result;
        f32_pkg::status_t status;
    } fp_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [31:0] s_operand_a;
    logic [31:0] s_operand_b;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_result;
    logic [1:0]  m_status;

    fp_word_t    expected_words[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          stall_mode = 0;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [31:0] HIDDEN = 32'h0080_0000;

    float32_add_sub_mul_div_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result(m_result), .m_status(m_status)
    );

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    function automatic fp_word_t fp_limit(logic sgn, int e, logic [31:0] m);
        fp_word_t w;
        w.result = 32'd0;
        w.status = f32_pkg::ST_OK;
        if (e > 255) w.status = f32_pkg::ST_OVF;
        else if (e < 1) w.status = f32_pkg::ST_UNF;
        else w.result = {sgn, e[7:0], m[22:0]};
        return w;
    endfunction

    function automatic fp_word_t fp_sum(logic sa, int ea, logic [31:0] ma,
                                        logic sb, int eb, logic [31:0] mb);
        fp_word_t w;
        logic sl;
        int el, es, d;
        logic [31:0] ml, ms, acc;
        w.result = 32'd0;
        w.status = f32_pkg::ST_OK;
        if (ea == 0 && eb == 0) return w;
        if (ea == 0) begin w.result = {sb, eb[7:0], mb[22:0]}; return w; end
        if (eb == 0) begin w.result = {sa, ea[7:0], ma[22:0]}; return w; end
        if ({ea[7:0], ma[23:0]} >= {eb[7:0], mb[23:0]}) begin
            sl = sa; el = ea; ml = ma; es = eb; ms = mb;
        end else begin
            sl = sb; el = eb; ml = mb; es = ea; ms = ma;
        end
        d = el - es;
        if (d >= f32_pkg::MANT_BITS) begin w.result = {sl, el[7:0], ml[22:0]}; return w; end
        ms = ms >> d;
        if (ms == 0) begin w.result = {sl, el[7:0], ml[22:0]}; return w; end
        if (sa == sb) begin
            acc = ml + ms;
            if (acc[24]) begin acc = acc >> 1; el++; end
        end else begin
            acc = ml - ms;
            if (acc == 0) return w;
            while (!(acc & HIDDEN)) begin acc = acc << 1; el--; end
        end
        return fp_limit(sl, el, acc);
    endfunction

    function automatic fp_word_t fp_predict(f32_pkg::op_t op, logic [31:0] a,
                                            logic [31:0] b);
        fp_word_t w;
        int ea, eb, e;
        logic [31:0] ma, mb;
        logic [63:0] p;
        logic sgn;
        ea = a[30:23];
        eb = b[30:23];
        ma = ea != 0 ? (HIDDEN | a[22:0]) : 32'd0;
        mb = eb != 0 ? (HIDDEN | b[22:0]) : 32'd0;
        sgn = a[31] ^ b[31];
        w.result = 32'd0;
        w.status = f32_pkg::ST_OK;
        case (op)
            f32_pkg::OP_ADD: w = fp_sum(a[31], ea, ma, b[31], eb, mb);
            f32_pkg::OP_SUB: w = fp_sum(a[31], ea, ma, ~b[31], eb, mb);
            f32_pkg::OP_MUL: begin
                if (ea != 0 && eb != 0) begin
                    p = {32'd0, ma} * {32'd0, mb};
                    e = ea + eb - f32_pkg::BIAS;
                    if (p[47]) begin
                        e++;
                        w = fp_limit(sgn, e, p[55:24]);
                    end else begin
                        w = fp_limit(sgn, e, p[54:23]);
                    end
                end
            end
            default: begin
                if (eb == 0) begin
                    w.status = f32_pkg::ST_DIVZ;
                end else if (ea != 0) begin
                    p = ({32'd0, ma} << f32_pkg::MANT_BITS) / {32'd0, mb};
                    e = ea - eb + f32_pkg::BIAS;
                    if (p[24]) begin
                        w = fp_limit(sgn, e, p[32:1]);
                    end else begin
                        e--;
                        w = fp_limit(sgn, e, p[31:0]);
                    end
                end
            end
        endcase
        return w;
    endfunction

    // receiver stall pattern changes at random among four modes
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (cycle_count % 5 != 0);
        endcase
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        fp_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word result=%h status=%0d", m_result, m_status);
                fail_count++;
            end else begin
                w = expected_words.pop_front();
                if (m_result !== w.result) begin
                    $error("result expected %h actual %h", w.result, m_result);
                    fail_count++;
                end
                if (m_status !== w.status) begin
                    $error("status expected %0d actual %0d", w.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_word(f32_pkg::op_t op, logic [31:0] a, logic [31:0] b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_req_type <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(fp_predict(op, a, b));
    endtask

    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'd0;
            1: v[30:23] = $urandom_range(0, 1) ? 8'd255 : 8'd1;
            2, 3, 4, 5: v[30:23] = 8'($urandom_range(100, 154));
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [31:0] vals[10];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h007F_FFFF, 32'h3F80_0000,
                 32'hBF80_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0080_0000,
                 32'h4B80_0000, 32'h3F80_0001};
        for (int k = 0; k < 5; k++) send_word(f32_pkg::op_t'(k % 4), vals[k], vals[k + 5]);
        send_word(f32_pkg::OP_SUB, 32'h3F80_0000, 32'h3F80_0000);
        send_word(f32_pkg::OP_ADD, 32'h3F80_0000, 32'hBF80_0000);
        send_word(f32_pkg::OP_ADD, 32'h4B80_0000, 32'h3F80_0000);
        send_word(f32_pkg::OP_SUB, 32'h3F80_0001, 32'h3F80_0000);
        send_word(f32_pkg::OP_SUB, 32'h0000_0000, 32'h3F80_0000);
        send_word(f32_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(f32_pkg::OP_MUL, 32'h7F00_0000, 32'h7F00_0000);
        send_word(f32_pkg::OP_MUL, 32'h0080_0000, 32'h0080_0000);
        send_word(f32_pkg::OP_MUL, 32'h0012_3456, 32'h3F80_0000);
        send_word(f32_pkg::OP_DIV, 32'h3F80_0000, 32'h0000_0000);
        send_word(f32_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000);
        send_word(f32_pkg::OP_DIV, 32'h0000_0000, 32'h3F80_0000);
        send_word(f32_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0080_0000);
        send_word(f32_pkg::OP_DIV, 32'h0080_0000, 32'h7FFF_FFFF);
        send_word(f32_pkg::OP_DIV, 32'h3FFF_FFFF, 32'h3F80_0001);
        send_word(f32_pkg::OP_SUB, 32'h0080_0001, 32'h0080_0000);
        send_word(f32_pkg::OP_ADD, 32'h0080_0000, 32'h8000_0000);
    endtask

    task automatic test_random();
        logic [31:0] a, b;
        for (int k = 0; k < 1030; k++) begin
            a = rand_fp();
            b = rand_fp();
            // near-equal operands drive long normalization
            if ($urandom_range(0, 5) == 0)
                b = {1'($urandom_range(0, 1)), a[30:0] ^ 31'($urandom & 32'h3)};
            send_word(f32_pkg::op_t'($urandom_range(0, 3)), a, b);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = f32_pkg::OP_ADD;
        s_operand_a = 32'd0;
        s_operand_b = 32'd0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
sv/f32_pkg.sv
sv/float32_add_sub_mul_div_core.sv
tb/sv/float32_add_sub_mul_div_core_tb.sv
